>>> hdl/arp_pkg.sv
// Shared types and constants of the address resolution engine.
// No dependencies; every other file of the block uses it.
package arp_pkg;

   localparam int CACHE_ENTRIES   = 16;
   localparam int PENDING_ENTRIES = 16;
   localparam int QUEUE_DEPTH     = 32;
   localparam int TAG_BITS        = 16;

   localparam int TAG_W  = (TAG_BITS < 16) ? TAG_BITS : 16;
   localparam int CI_W   = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int PI_W   = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
   localparam int QI_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int MAX_N  = (CACHE_ENTRIES > PENDING_ENTRIES) ?
                           ((CACHE_ENTRIES > QUEUE_DEPTH) ? CACHE_ENTRIES : QUEUE_DEPTH) :
                           ((PENDING_ENTRIES > QUEUE_DEPTH) ? PENDING_ENTRIES : QUEUE_DEPTH);
   localparam int SCAN_W = $clog2(MAX_N + 1);

   localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;
   localparam logic [15:0] IPV4_ETHERTYPE = 16'h0800;
   localparam logic [15:0] ARP_ETHERTYPE  = 16'h0806;
   localparam logic [15:0] OP_REQUEST = 16'd1;
   localparam logic [15:0] OP_REPLY   = 16'd2;

   localparam logic [1:0] ACT_SEND      = 2'd0;
   localparam logic [1:0] ACT_FRAME     = 2'd1;
   localparam logic [1:0] ACT_TICK      = 2'd2;
   localparam logic [1:0] ACT_UNDEFINED = 2'd3;

   localparam logic [2:0] KIND_IPV4    = 3'd0;
   localparam logic [2:0] KIND_REQUEST = 3'd1;
   localparam logic [2:0] KIND_REPLY   = 3'd2;
   localparam logic [2:0] KIND_DELIVER = 3'd3;
   localparam logic [2:0] KIND_DROP    = 3'd4;

   localparam logic [1:0] REG_LOCAL_MAC = 2'd0;
   localparam logic [1:0] REG_LOCAL_IP  = 2'd1;
   localparam logic [1:0] REG_LIFETIME  = 2'd2;
   localparam logic [1:0] REG_RETRY     = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] hop_ip;
      logic [15:0] datagram_tag;
      logic [47:0] frame_dst_mac;
      logic [15:0] frame_type;
      logic        payload_ok;
      logic [15:0] arp_opcode;
      logic [31:0] sender_ip;
      logic [47:0] sender_mac;
      logic [31:0] target_ip;
      logic [47:0] target_mac;
      logic [15:0] elapsed_ms;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [47:0] dest_mac;
      logic [31:0] arp_target_ip;
      logic [47:0] arp_target_mac;
      logic [15:0] out_tag;
      logic        last;
   } rsp_payload_type;

   typedef struct packed {
      logic [47:0] local_mac;
      logic [31:0] local_ip;
      logic [15:0] entry_lifetime_ms;
      logic [15:0] retry_interval_ms;
   } cfg_type;

   typedef struct packed {
      logic            emit;
      logic            finish;
      rsp_payload_type data;
   } emit_type;

endpackage

>>> hdl/arp_req_if.sv
// Input channel of the address resolution engine.
// Depends on arp_pkg.
interface arp_req_if;
   logic                      valid;
   logic                      ready;
   arp_pkg::req_payload_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/arp_rsp_if.sv
// Result channel of the address resolution engine.
// Depends on arp_pkg.
interface arp_rsp_if;
   logic                      valid;
   logic                      ready;
   arp_pkg::rsp_payload_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/arp_out_stage.sv
// Result holding stage: delays each result by one so the final one carries last,
// and registers the result channel. Depends on arp_pkg.
module arp_out_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  arp_pkg::emit_type        emit,
   output logic                     go,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output arp_pkg::rsp_payload_type rsp_data
);

   logic                     hold_v_ff, hold_v_in;
   arp_pkg::rsp_payload_type hold_ff, hold_in;
   logic                     out_v_ff, out_v_in;
   arp_pkg::rsp_payload_type out_ff, out_in;

   assign go        = !out_v_ff || rsp_ready;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      hold_v_in = hold_v_ff;
      hold_in   = hold_ff;
      out_v_in  = out_v_ff && !rsp_ready;
      out_in    = out_ff;
      if (go && emit.emit) begin
         if (hold_v_ff) begin
            out_v_in     = 1'b1;
            out_in       = hold_ff;
            out_in.last  = 1'b0;
         end
         hold_v_in = 1'b1;
         hold_in   = emit.data;
      end else if (go && emit.finish && hold_v_ff) begin
         out_v_in    = 1'b1;
         out_in      = hold_ff;
         out_in.last = 1'b1;
         hold_v_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         hold_v_ff <= hold_v_in;
         out_v_ff  <= out_v_in;
      end
      hold_ff <= hold_in;
      out_ff  <= out_in;
   end

endmodule

>>> hdl/arp_engine.sv
// Sequencer with the cache, pending and queue memories: scans each entry with a read
// state, then an evaluate state that writes back. Depends on arp_pkg.
module arp_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  arp_pkg::req_payload_type req_data,
   input  arp_pkg::cfg_type         cfg,
   output arp_pkg::emit_type        emit,
   input  logic                     go
);

   typedef enum logic [18:0] {
      ST_IDLE     = 19'h00001,
      ST_FR_DEC   = 19'h00002,
      ST_C_RD     = 19'h00004,
      ST_C_EV     = 19'h00008,
      ST_SEND_DEC = 19'h00010,
      ST_P_RD     = 19'h00020,
      ST_P_EV     = 19'h00040,
      ST_SEND_FIN = 19'h00080,
      ST_L_WR     = 19'h00100,
      ST_Q_RD     = 19'h00200,
      ST_Q_EV     = 19'h00400,
      ST_PC_RD    = 19'h00800,
      ST_PC_EV    = 19'h01000,
      ST_TP_RD    = 19'h02000,
      ST_TP_EV    = 19'h04000,
      ST_TS_RD    = 19'h08000,
      ST_TS_EV    = 19'h10000,
      ST_TS_EMIT  = 19'h20000,
      ST_DONE     = 19'h40000
   } state_type;

   typedef enum logic [1:0] {MODE_SEND, MODE_LEARN, MODE_TICK} mode_type;

   typedef struct packed {
      logic [31:0] ip;
      logic [47:0] mac;
      logic [15:0] ttl;
   } cache_entry_type;

   typedef struct packed {
      logic [31:0] ip;
      logic [15:0] ttl;
   } pend_entry_type;

   typedef struct packed {
      logic [31:0]                ip;
      logic [arp_pkg::TAG_W-1:0] tag;
   } queue_entry_type;

   cache_entry_type cache_mem_ff [arp_pkg::CACHE_ENTRIES];
   pend_entry_type  pend_mem_ff  [arp_pkg::PENDING_ENTRIES];
   queue_entry_type queue_mem_ff [arp_pkg::QUEUE_DEPTH];

   cache_entry_type c_rdata_ff, c_wdata;
   pend_entry_type  p_rdata_ff, p_wdata;
   queue_entry_type q_rdata_ff, q_wdata;
   logic                     c_re, c_we, p_re, p_we, q_re, q_we;
   logic [arp_pkg::CI_W-1:0] c_waddr;
   logic [arp_pkg::PI_W-1:0] p_waddr;
   logic [arp_pkg::QI_W-1:0] q_waddr;

   state_type                 state_ff, state_in;
   mode_type                  mode_ff, mode_in;
   arp_pkg::req_payload_type  item_ff, item_in;
   logic [arp_pkg::SCAN_W-1:0] idx_ff, idx_in;
   logic [arp_pkg::CACHE_ENTRIES-1:0]   cvalid_ff, cvalid_in;
   logic [arp_pkg::PENDING_ENTRIES-1:0] pvalid_ff, pvalid_in, due_ff, due_in;
   logic [arp_pkg::QC_W-1:0]  qcount_ff, qcount_in, w_ff, w_in;
   logic                      hit_ff, hit_in, free_ff, free_in;
   logic [arp_pkg::CI_W-1:0]  hit_idx_ff, hit_idx_in, free_idx_ff, free_idx_in;
   logic [arp_pkg::CI_W-1:0]  min_idx_ff, min_idx_in;
   logic [15:0]               min_ttl_ff, min_ttl_in;
   logic [47:0]               hit_mac_ff, hit_mac_in;
   logic                      pmatch_ff, pmatch_in, pfree_ff, pfree_in;
   logic [arp_pkg::PI_W-1:0]  pfree_idx_ff, pfree_idx_in, best_idx_ff, best_idx_in;
   logic                      found_ff, found_in;
   logic [31:0]               best_ip_ff, best_ip_in;

   logic                      adv;
   logic [31:0]               key_ip;
   logic [arp_pkg::CI_W-1:0]  ci;
   logic [arp_pkg::PI_W-1:0]  pi;
   logic [arp_pkg::QI_W-1:0]  qi;
   logic                      c_last, p_last, q_last;
   logic                      dst_ok, is_req, is_rep;
   logic [arp_pkg::QC_W-1:0]  w_next;

   assign ci     = idx_ff[arp_pkg::CI_W-1:0];
   assign pi     = idx_ff[arp_pkg::PI_W-1:0];
   assign qi     = idx_ff[arp_pkg::QI_W-1:0];
   assign c_last = idx_ff == arp_pkg::SCAN_W'(arp_pkg::CACHE_ENTRIES - 1);
   assign p_last = idx_ff == arp_pkg::SCAN_W'(arp_pkg::PENDING_ENTRIES - 1);
   assign q_last = (arp_pkg::QC_W'(idx_ff) + arp_pkg::QC_W'(1)) == qcount_ff;
   assign key_ip = (mode_ff == MODE_SEND) ? item_ff.hop_ip : item_ff.sender_ip;
   assign dst_ok = (item_ff.frame_dst_mac == cfg.local_mac) ||
                   (item_ff.frame_dst_mac == arp_pkg::BCAST_MAC);
   assign is_req = (item_ff.arp_opcode == arp_pkg::OP_REQUEST) &&
                   (item_ff.target_ip == cfg.local_ip);
   assign is_rep = (item_ff.arp_opcode == arp_pkg::OP_REPLY) &&
                   (item_ff.target_mac == cfg.local_mac);
   assign adv    = go || !(emit.emit || emit.finish);
   assign req_ready = state_ff == ST_IDLE;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      item_in      = item_ff;
      idx_in       = idx_ff;
      cvalid_in    = cvalid_ff;
      pvalid_in    = pvalid_ff;
      due_in       = due_ff;
      qcount_in    = qcount_ff;
      w_in         = w_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_mac_in   = hit_mac_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      min_idx_in   = min_idx_ff;
      min_ttl_in   = min_ttl_ff;
      pmatch_in    = pmatch_ff;
      pfree_in     = pfree_ff;
      pfree_idx_in = pfree_idx_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_ip_in   = best_ip_ff;
      emit         = '0;
      c_re = 1'b0; c_we = 1'b0; c_waddr = ci; c_wdata = c_rdata_ff;
      p_re = 1'b0; p_we = 1'b0; p_waddr = pi; p_wdata = p_rdata_ff;
      q_re = 1'b0; q_we = 1'b0; q_waddr = qi; q_wdata = q_rdata_ff;
      w_next = w_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in   = req_data;
               idx_in    = '0;
               hit_in    = 1'b0;
               free_in   = 1'b0;
               pmatch_in = 1'b0;
               pfree_in  = 1'b0;
               found_in  = 1'b0;
               unique case (req_data.action)
                  arp_pkg::ACT_SEND: begin
                     mode_in  = MODE_SEND;
                     state_in = ST_C_RD;
                  end
                  arp_pkg::ACT_FRAME: state_in = ST_FR_DEC;
                  arp_pkg::ACT_TICK: begin
                     mode_in  = MODE_TICK;
                     state_in = ST_C_RD;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_FR_DEC: begin
            state_in = ST_DONE;
            if (dst_ok && item_ff.payload_ok) begin
               if (item_ff.frame_type == arp_pkg::IPV4_ETHERTYPE) begin
                  emit.emit             = 1'b1;
                  emit.data.result_kind = arp_pkg::KIND_DELIVER;
               end else if (item_ff.frame_type == arp_pkg::ARP_ETHERTYPE &&
                            (is_req || is_rep)) begin
                  if (is_req) begin
                     emit.emit                = 1'b1;
                     emit.data.result_kind    = arp_pkg::KIND_REPLY;
                     emit.data.dest_mac       = item_ff.sender_mac;
                     emit.data.arp_target_ip  = item_ff.sender_ip;
                     emit.data.arp_target_mac = item_ff.sender_mac;
                  end
                  mode_in  = MODE_LEARN;
                  state_in = ST_C_RD;
               end
            end
         end
         ST_C_RD: begin
            c_re     = 1'b1;
            state_in = ST_C_EV;
         end
         ST_C_EV: begin
            if (mode_ff == MODE_TICK) begin
               if (cvalid_ff[ci]) begin
                  if (c_rdata_ff.ttl <= item_ff.elapsed_ms) begin
                     cvalid_in[ci] = 1'b0;
                  end else begin
                     c_we        = 1'b1;
                     c_wdata.ttl = c_rdata_ff.ttl - item_ff.elapsed_ms;
                  end
               end
            end else begin
               if (cvalid_ff[ci] && c_rdata_ff.ip == key_ip && !hit_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = ci;
                  hit_mac_in = c_rdata_ff.mac;
               end
               if (!cvalid_ff[ci] && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = ci;
               end
               if (idx_ff == '0 || c_rdata_ff.ttl < min_ttl_ff) begin
                  min_ttl_in = c_rdata_ff.ttl;
                  min_idx_in = ci;
               end
            end
            if (c_last) begin
               idx_in = '0;
               unique case (mode_ff)
                  MODE_SEND:  state_in = ST_SEND_DEC;
                  MODE_LEARN: state_in = ST_L_WR;
                  default:    state_in = ST_TP_RD;
               endcase
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_C_RD;
            end
         end
         ST_SEND_DEC: begin
            state_in = ST_DONE;
            if (hit_ff) begin
               emit.emit             = 1'b1;
               emit.data.result_kind = arp_pkg::KIND_IPV4;
               emit.data.dest_mac    = hit_mac_ff;
               emit.data.out_tag     = 16'(arp_pkg::TAG_W'(item_ff.datagram_tag));
            end else if (qcount_ff >= arp_pkg::QC_W'(arp_pkg::QUEUE_DEPTH)) begin
               emit.emit             = 1'b1;
               emit.data.result_kind = arp_pkg::KIND_DROP;
               emit.data.out_tag     = 16'(arp_pkg::TAG_W'(item_ff.datagram_tag));
            end else begin
               idx_in   = '0;
               state_in = ST_P_RD;
            end
         end
         ST_P_RD: begin
            p_re     = 1'b1;
            state_in = ST_P_EV;
         end
         ST_P_EV: begin
            if (pvalid_ff[pi] && p_rdata_ff.ip == item_ff.hop_ip) begin
               pmatch_in = 1'b1;
            end
            if (!pvalid_ff[pi] && !pfree_ff) begin
               pfree_in     = 1'b1;
               pfree_idx_in = pi;
            end
            if (p_last) begin
               state_in = ST_SEND_FIN;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_P_RD;
            end
         end
         ST_SEND_FIN: begin
            state_in = ST_DONE;
            if (!pmatch_ff && !pfree_ff) begin
               emit.emit             = 1'b1;
               emit.data.result_kind = arp_pkg::KIND_DROP;
               emit.data.out_tag     = 16'(arp_pkg::TAG_W'(item_ff.datagram_tag));
            end else begin
               if (!pmatch_ff) begin
                  emit.emit               = 1'b1;
                  emit.data.result_kind   = arp_pkg::KIND_REQUEST;
                  emit.data.dest_mac      = arp_pkg::BCAST_MAC;
                  emit.data.arp_target_ip = item_ff.hop_ip;
                  p_we                    = 1'b1;
                  p_waddr                 = pfree_idx_ff;
                  p_wdata.ip              = item_ff.hop_ip;
                  p_wdata.ttl             = cfg.retry_interval_ms;
                  pvalid_in[pfree_idx_ff] = 1'b1;
               end
               q_we        = 1'b1;
               q_waddr     = qcount_ff[arp_pkg::QI_W-1:0];
               q_wdata.ip  = item_ff.hop_ip;
               q_wdata.tag = arp_pkg::TAG_W'(item_ff.datagram_tag);
               qcount_in   = qcount_ff + 1'b1;
            end
         end
         ST_L_WR: begin
            c_we        = 1'b1;
            c_waddr     = hit_ff ? hit_idx_ff : (free_ff ? free_idx_ff : min_idx_ff);
            c_wdata.ip  = item_ff.sender_ip;
            c_wdata.mac = item_ff.sender_mac;
            c_wdata.ttl = cfg.entry_lifetime_ms;
            cvalid_in[c_waddr] = 1'b1;
            idx_in      = '0;
            w_in        = '0;
            state_in    = (qcount_ff == '0) ? ST_PC_RD : ST_Q_RD;
         end
         ST_Q_RD: begin
            q_re     = 1'b1;
            state_in = ST_Q_EV;
         end
         ST_Q_EV: begin
            if (q_rdata_ff.ip == item_ff.sender_ip) begin
               emit.emit             = 1'b1;
               emit.data.result_kind = arp_pkg::KIND_IPV4;
               emit.data.dest_mac    = item_ff.sender_mac;
               emit.data.out_tag     = 16'(q_rdata_ff.tag);
            end else begin
               q_we    = 1'b1;
               q_waddr = w_ff[arp_pkg::QI_W-1:0];
               q_wdata = q_rdata_ff;
               w_next  = w_ff + 1'b1;
            end
            w_in = w_next;
            if (q_last) begin
               qcount_in = w_next;
               idx_in    = '0;
               state_in  = ST_PC_RD;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_Q_RD;
            end
         end
         ST_PC_RD: begin
            p_re     = 1'b1;
            state_in = ST_PC_EV;
         end
         ST_PC_EV: begin
            if (pvalid_ff[pi] && p_rdata_ff.ip == item_ff.sender_ip) begin
               pvalid_in[pi] = 1'b0;
            end
            if (p_last) begin
               state_in = ST_DONE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_PC_RD;
            end
         end
         ST_TP_RD: begin
            p_re     = 1'b1;
            state_in = ST_TP_EV;
         end
         ST_TP_EV: begin
            if (pvalid_ff[pi]) begin
               if (p_rdata_ff.ttl <= item_ff.elapsed_ms) begin
                  due_in[pi] = 1'b1;
               end else begin
                  p_we        = 1'b1;
                  p_wdata.ttl = p_rdata_ff.ttl - item_ff.elapsed_ms;
               end
            end
            if (p_last) begin
               idx_in   = '0;
               found_in = 1'b0;
               state_in = ST_TS_RD;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_TP_RD;
            end
         end
         ST_TS_RD: begin
            p_re     = 1'b1;
            state_in = ST_TS_EV;
         end
         ST_TS_EV: begin
            if (due_ff[pi] && (!found_ff || p_rdata_ff.ip < best_ip_ff)) begin
               found_in    = 1'b1;
               best_idx_in = pi;
               best_ip_in  = p_rdata_ff.ip;
            end
            if (p_last) begin
               state_in = ST_TS_EMIT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_TS_RD;
            end
         end
         ST_TS_EMIT: begin
            if (!found_ff) begin
               state_in = ST_DONE;
            end else begin
               emit.emit               = 1'b1;
               emit.data.result_kind   = arp_pkg::KIND_REQUEST;
               emit.data.dest_mac      = arp_pkg::BCAST_MAC;
               emit.data.arp_target_ip = best_ip_ff;
               p_we                    = 1'b1;
               p_waddr                 = best_idx_ff;
               p_wdata.ip              = best_ip_ff;
               p_wdata.ttl             = cfg.retry_interval_ms;
               due_in[best_idx_ff]     = 1'b0;
               idx_in                  = '0;
               found_in                = 1'b0;
               state_in                = ST_TS_RD;
            end
         end
         ST_DONE: begin
            emit.finish = 1'b1;
            state_in    = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv && c_we) cache_mem_ff[c_waddr] <= c_wdata;
      if (adv && c_re) c_rdata_ff <= cache_mem_ff[ci];
      if (adv && p_we) pend_mem_ff[p_waddr] <= p_wdata;
      if (adv && p_re) p_rdata_ff <= pend_mem_ff[pi];
      if (adv && q_we) queue_mem_ff[q_waddr] <= q_wdata;
      if (adv && q_re) q_rdata_ff <= queue_mem_ff[qi];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cvalid_ff <= '0;
         pvalid_ff <= '0;
         due_ff    <= '0;
         qcount_ff <= '0;
      end else if (adv) begin
         state_ff  <= state_in;
         cvalid_ff <= cvalid_in;
         pvalid_ff <= pvalid_in;
         due_ff    <= due_in;
         qcount_ff <= qcount_in;
      end
      if (adv) begin
         mode_ff      <= mode_in;
         item_ff      <= item_in;
         idx_ff       <= idx_in;
         w_ff         <= w_in;
         hit_ff       <= hit_in;
         hit_idx_ff   <= hit_idx_in;
         hit_mac_ff   <= hit_mac_in;
         free_ff      <= free_in;
         free_idx_ff  <= free_idx_in;
         min_idx_ff   <= min_idx_in;
         min_ttl_ff   <= min_ttl_in;
         pmatch_ff    <= pmatch_in;
         pfree_ff     <= pfree_in;
         pfree_idx_ff <= pfree_idx_in;
         found_ff     <= found_in;
         best_idx_ff  <= best_idx_in;
         best_ip_ff   <= best_ip_in;
      end
   end

endmodule

>>> hdl/arp_resolution_engine.sv
// Top level of the address resolution engine: register port, sequencer, result stage.
// Depends on arp_pkg, arp_req_if, arp_rsp_if, arp_engine and arp_out_stage.
//
//   channel   direction  handshake              payload
//   req_ch    in         valid/ready            send, received frame or tick
//   rsp_ch    out        valid/ready            one result per transfer, last marks the end
//   csr_*     in         APB, pready tied high  four registers at byte address 8*i
//
// One item at a time; each memory entry takes a read state, then an evaluate-and-write state.
// Send scans the cache, then the pending table; a learned ARP frame scans the cache, the queue and
// the pending table; a tick scans the cache and the pending table, then rescans the pending table.
// Reset is synchronous and clears the valid bits and the queue count at once.
// A stalled result channel freezes the sequencer at its next result.
module arp_resolution_engine (
   input  logic        clock,
   input  logic        reset,
   arp_req_if.sink     req_ch,
   arp_rsp_if.source   rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   arp_pkg::cfg_type  cfg_ff, cfg_in;
   arp_pkg::emit_type emit;
   logic              go;
   logic              wr_en;
   logic [1:0]        reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[4:3];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            arp_pkg::REG_LOCAL_MAC: cfg_in.local_mac         = csr_pwdata[47:0];
            arp_pkg::REG_LOCAL_IP:  cfg_in.local_ip          = csr_pwdata[31:0];
            arp_pkg::REG_LIFETIME:  cfg_in.entry_lifetime_ms = csr_pwdata[15:0];
            arp_pkg::REG_RETRY:     cfg_in.retry_interval_ms = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         arp_pkg::REG_LOCAL_MAC: csr_prdata = {16'd0, cfg_ff.local_mac};
         arp_pkg::REG_LOCAL_IP:  csr_prdata = {32'd0, cfg_ff.local_ip};
         arp_pkg::REG_LIFETIME:  csr_prdata = {48'd0, cfg_ff.entry_lifetime_ms};
         arp_pkg::REG_RETRY:     csr_prdata = {48'd0, cfg_ff.retry_interval_ms};
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.local_mac         <= '0;
         cfg_ff.local_ip          <= '0;
         cfg_ff.entry_lifetime_ms <= 16'd30000;
         cfg_ff.retry_interval_ms <= 16'd5000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   arp_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_data  (req_ch.payload),
      .cfg       (cfg_ff),
      .emit      (emit),
      .go        (go)
   );

   arp_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .emit      (emit),
      .go        (go),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_data  (rsp_ch.payload)
   );

endmodule

>>> verif/tb_arp_resolution_engine.sv
// Self-checking testbench of arp_resolution_engine: a clocked driver and monitor, an
// in-bench resolver that predicts every result, directed and random traffic under idling.
// Depends on arp_pkg, arp_req_if, arp_rsp_if and the arp_resolution_engine RTL.
`timescale 1ns / 100ps

module tb_arp_resolution_engine;

   localparam int LIMIT_CYCLES = 1500000;
   localparam int QUIET_CYCLES = 800;
   localparam int POOL_SIZE    = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   arp_req_if req_if ();
   arp_rsp_if rsp_if ();

   arp_resolution_engine DUT (
      .clock(clock), .reset(reset), .req_ch(req_if.sink), .rsp_ch(rsp_if.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   // resolver state
   logic [47:0] my_mac;
   logic [31:0] my_ip;
   logic [15:0] lifetime_ms;
   logic [15:0] retry_ms;
   logic        arp_valid [arp_pkg::CACHE_ENTRIES];
   logic [31:0] arp_ip [arp_pkg::CACHE_ENTRIES];
   logic [47:0] arp_mac [arp_pkg::CACHE_ENTRIES];
   logic [15:0] arp_ttl [arp_pkg::CACHE_ENTRIES];
   logic        wait_valid [arp_pkg::PENDING_ENTRIES];
   logic [31:0] wait_ip [arp_pkg::PENDING_ENTRIES];
   logic [15:0] wait_ttl [arp_pkg::PENDING_ENTRIES];
   logic [31:0] held_ip [arp_pkg::QUEUE_DEPTH];
   logic [15:0] held_tag [arp_pkg::QUEUE_DEPTH];
   int          held_count;

   arp_pkg::req_payload_type queued_requests[$];
   arp_pkg::rsp_payload_type expected_results[$];
   logic [31:0]              ip_pool [POOL_SIZE];

   int   errors = 0;
   int   cycle_count = 0;
   int   send_gap_pct = 0;
   int   recv_stall_pct = 0;
   logic send_hold = 1'b0;
   logic hold_arm = 1'b0;
   logic hold_seen = 1'b0;
   int   hold_count = 0;

   function automatic void push_result(logic [2:0] kind, logic [47:0] dmac, logic [31:0] tip,
                                       logic [47:0] tmac, logic [15:0] tag);
      arp_pkg::rsp_payload_type r;
      r.result_kind = kind;
      r.dest_mac = dmac;
      r.arp_target_ip = tip;
      r.arp_target_mac = tmac;
      r.out_tag = tag;
      r.last = 1'b0;
      expected_results.insert(expected_results.size(), r);
   endfunction

   function automatic void queue_item(arp_pkg::req_payload_type it);
      queued_requests.insert(queued_requests.size(), it);
   endfunction

   function automatic int find_arp(logic [31:0] ip);
      for (int i = 0; i < arp_pkg::CACHE_ENTRIES; i++)
         if (arp_valid[i] && arp_ip[i] == ip) return i;
      return -1;
   endfunction

   function automatic int find_wait(logic [31:0] ip);
      for (int i = 0; i < arp_pkg::PENDING_ENTRIES; i++)
         if (wait_valid[i] && wait_ip[i] == ip) return i;
      return -1;
   endfunction

   function automatic void model_send(logic [31:0] ip, logic [15:0] tag);
      int c;
      int p;
      c = find_arp(ip);
      if (c >= 0) begin
         push_result(arp_pkg::KIND_IPV4, arp_mac[c], '0, '0, tag);
         return;
      end
      if (held_count >= arp_pkg::QUEUE_DEPTH) begin
         push_result(arp_pkg::KIND_DROP, '0, '0, '0, tag);
         return;
      end
      if (find_wait(ip) < 0) begin
         p = -1;
         for (int i = 0; i < arp_pkg::PENDING_ENTRIES; i++)
            if (!wait_valid[i] && p < 0) p = i;
         if (p < 0) begin
            push_result(arp_pkg::KIND_DROP, '0, '0, '0, tag);
            return;
         end
         push_result(arp_pkg::KIND_REQUEST, arp_pkg::BCAST_MAC, ip, '0, '0);
         wait_valid[p] = 1'b1;
         wait_ip[p] = ip;
         wait_ttl[p] = retry_ms;
      end
      held_ip[held_count] = ip;
      held_tag[held_count] = tag;
      held_count++;
   endfunction

   function automatic void learn_mapping(logic [31:0] ip, logic [47:0] mac);
      int slot;
      slot = find_arp(ip);
      if (slot < 0)
         for (int i = 0; i < arp_pkg::CACHE_ENTRIES; i++)
            if (!arp_valid[i] && slot < 0) slot = i;
      if (slot < 0) begin
         slot = 0;
         for (int i = 1; i < arp_pkg::CACHE_ENTRIES; i++)
            if (arp_ttl[i] < arp_ttl[slot]) slot = i;
      end
      arp_valid[slot] = 1'b1;
      arp_ip[slot] = ip;
      arp_mac[slot] = mac;
      arp_ttl[slot] = lifetime_ms;
   endfunction

   function automatic void receive_frame(arp_pkg::req_payload_type it);
      logic is_req;
      logic is_rep;
      int   w;
      int   cnt;
      int   p;
      if (it.frame_dst_mac != my_mac && it.frame_dst_mac != arp_pkg::BCAST_MAC) return;
      if (!it.payload_ok) return;
      if (it.frame_type == arp_pkg::IPV4_ETHERTYPE) begin
         push_result(arp_pkg::KIND_DELIVER, '0, '0, '0, '0);
         return;
      end
      if (it.frame_type != arp_pkg::ARP_ETHERTYPE) return;
      is_req = (it.arp_opcode == arp_pkg::OP_REQUEST) && (it.target_ip == my_ip);
      is_rep = (it.arp_opcode == arp_pkg::OP_REPLY) && (it.target_mac == my_mac);
      if (is_req)
         push_result(arp_pkg::KIND_REPLY, it.sender_mac, it.sender_ip, it.sender_mac, '0);
      if (is_req || is_rep) begin
         learn_mapping(it.sender_ip, it.sender_mac);
         w = 0;
         cnt = held_count;
         for (int i = 0; i < cnt; i++) begin
            if (held_ip[i] == it.sender_ip) begin
               model_send(it.sender_ip, held_tag[i]);
            end else begin
               held_ip[w] = held_ip[i];
               held_tag[w] = held_tag[i];
               w++;
            end
         end
         held_count = w;
         p = find_wait(it.sender_ip);
         if (p >= 0) wait_valid[p] = 1'b0;
      end
   endfunction

   function automatic void age_tables(logic [15:0] elapsed);
      logic due [arp_pkg::PENDING_ENTRIES];
      int   best;
      for (int i = 0; i < arp_pkg::CACHE_ENTRIES; i++)
         if (arp_valid[i]) begin
            if (arp_ttl[i] <= elapsed) arp_valid[i] = 1'b0;
            else arp_ttl[i] = arp_ttl[i] - elapsed;
         end
      for (int i = 0; i < arp_pkg::PENDING_ENTRIES; i++) begin
         due[i] = 1'b0;
         if (wait_valid[i]) begin
            if (wait_ttl[i] <= elapsed) due[i] = 1'b1;
            else wait_ttl[i] = wait_ttl[i] - elapsed;
         end
      end
      do begin
         best = -1;
         for (int i = 0; i < arp_pkg::PENDING_ENTRIES; i++)
            if (due[i] && (best < 0 || wait_ip[i] < wait_ip[best])) best = i;
         if (best >= 0) begin
            due[best] = 1'b0;
            push_result(arp_pkg::KIND_REQUEST, arp_pkg::BCAST_MAC, wait_ip[best], '0, '0);
            wait_ttl[best] = retry_ms;
         end
      end while (best >= 0);
   endfunction

   function automatic void resolve_item(arp_pkg::req_payload_type it);
      int before_n;
      arp_pkg::rsp_payload_type r;
      before_n = expected_results.size();
      case (it.action)
         arp_pkg::ACT_SEND:  model_send(it.hop_ip, it.datagram_tag);
         arp_pkg::ACT_FRAME: receive_frame(it);
         arp_pkg::ACT_TICK:  age_tables(it.elapsed_ms);
         default: ;
      endcase
      if (expected_results.size() > before_n) begin
         r = expected_results[expected_results.size() - 1];
         r.last = 1'b1;
         expected_results[expected_results.size() - 1] = r;
      end
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin
      if (req_if.valid && req_if.ready) resolve_item(req_if.payload);
      if (!reset && (!req_if.valid || req_if.ready)) begin
         if (queued_requests.size() > 0 && !send_hold &&
             $urandom_range(99) >= send_gap_pct) begin
            req_if.valid <= 1'b1;
            req_if.payload <= queued_requests.pop_front();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_arm != hold_seen) begin
         hold_seen <= hold_arm;
         hold_count <= 600;
      end else if (hold_count > 0) begin
         hold_count <= hold_count - 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      arp_pkg::rsp_payload_type got;
      arp_pkg::rsp_payload_type want;
      if (rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         if (expected_results.size() == 0) begin
            report("unexpected transfer, kind", 64'(got.result_kind), '0);
         end else begin
            want = expected_results.pop_front();
            if (got.result_kind != want.result_kind)
               report("result_kind", 64'(got.result_kind), 64'(want.result_kind));
            if (got.dest_mac != want.dest_mac)
               report("dest_mac", 64'(got.dest_mac), 64'(want.dest_mac));
            if (got.arp_target_ip != want.arp_target_ip)
               report("arp_target_ip", 64'(got.arp_target_ip), 64'(want.arp_target_ip));
            if (got.arp_target_mac != want.arp_target_mac)
               report("arp_target_mac", 64'(got.arp_target_mac), 64'(want.arp_target_mac));
            if (got.out_tag != want.out_tag)
               report("out_tag", 64'(got.out_tag), 64'(want.out_tag));
            if (got.last != want.last) report("last", 64'(got.last), 64'(want.last));
         end
      end
      rsp_if.ready <= !reset && hold_count == 0 && $urandom_range(99) >= recv_stall_pct;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("arp_resolution_engine: mismatch");
         $finish;
      end
   end

   function automatic logic [47:0] rand_mac();
      return {16'($urandom_range(65535)), $urandom()};
   endfunction

   function automatic arp_pkg::req_payload_type noise_item();
      arp_pkg::req_payload_type it;
      it.action = 2'($urandom_range(3));
      it.hop_ip = $urandom();
      it.datagram_tag = 16'($urandom_range(65535));
      it.frame_dst_mac = rand_mac();
      it.frame_type = 16'($urandom_range(65535));
      it.payload_ok = 1'($urandom_range(1));
      it.arp_opcode = 16'($urandom_range(65535));
      it.sender_ip = $urandom();
      it.sender_mac = rand_mac();
      it.target_ip = $urandom();
      it.target_mac = rand_mac();
      it.elapsed_ms = 16'($urandom_range(65535));
      return it;
   endfunction

   function automatic arp_pkg::req_payload_type send_item(logic [31:0] ip, logic [15:0] tag);
      arp_pkg::req_payload_type it;
      it = noise_item();
      it.action = arp_pkg::ACT_SEND;
      it.hop_ip = ip;
      it.datagram_tag = tag;
      return it;
   endfunction

   function automatic arp_pkg::req_payload_type frame_item(logic [47:0] dst,
                                                           logic [15:0] ftype, logic ok);
      arp_pkg::req_payload_type it;
      it = noise_item();
      it.action = arp_pkg::ACT_FRAME;
      it.frame_dst_mac = dst;
      it.frame_type = ftype;
      it.payload_ok = ok;
      return it;
   endfunction

   function automatic arp_pkg::req_payload_type arp_item(logic [15:0] op, logic [31:0] sip,
                                                         logic [31:0] tip, logic [47:0] tmac);
      arp_pkg::req_payload_type it;
      it = frame_item(($urandom_range(1) != 0) ? my_mac : arp_pkg::BCAST_MAC,
                      arp_pkg::ARP_ETHERTYPE, 1'b1);
      it.arp_opcode = op;
      it.sender_ip = sip;
      it.target_ip = tip;
      it.target_mac = tmac;
      return it;
   endfunction

   function automatic arp_pkg::req_payload_type tick_item(logic [15:0] elapsed);
      arp_pkg::req_payload_type it;
      it = noise_item();
      it.action = arp_pkg::ACT_TICK;
      it.elapsed_ms = elapsed;
      return it;
   endfunction

   function automatic arp_pkg::req_payload_type mixed_item();
      int r;
      logic [31:0] ip;
      r = int'($urandom_range(99));
      ip = ip_pool[$urandom_range(POOL_SIZE - 1)];
      if (r < 40) return send_item(ip, 16'($urandom_range(65535)));
      if (r < 58) return arp_item(arp_pkg::OP_REPLY, ip, $urandom(), my_mac);
      if (r < 66) return arp_item(arp_pkg::OP_REQUEST, ip, my_ip, rand_mac());
      if (r < 74) return tick_item(16'($urandom_range(2000)));
      if (r < 78) return tick_item(16'($urandom_range(65535)));
      if (r < 84) return frame_item(my_mac, arp_pkg::IPV4_ETHERTYPE, 1'($urandom_range(1)));
      return noise_item();
   endfunction

   task automatic write_reg(logic [1:0] index, logic [63:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (index)
         arp_pkg::REG_LOCAL_MAC: my_mac = value[47:0];
         arp_pkg::REG_LOCAL_IP:  my_ip = value[31:0];
         arp_pkg::REG_LIFETIME:  lifetime_ms = value[15:0];
         default:                retry_ms = value[15:0];
      endcase
   endtask

   task automatic drain();
      while (queued_requests.size() > 0 || req_if.valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic configure(logic [47:0] mac, logic [31:0] ip, logic [15:0] life,
                            logic [15:0] retry);
      write_reg(arp_pkg::REG_LOCAL_MAC, {16'h0, mac});
      write_reg(arp_pkg::REG_LOCAL_IP, {32'h0, ip});
      write_reg(arp_pkg::REG_LIFETIME, {48'h0, life});
      write_reg(arp_pkg::REG_RETRY, {48'h0, retry});
   endtask

   task automatic new_pool();
      logic [31:0] base;
      base = $urandom();
      for (int i = 0; i < POOL_SIZE; i++) ip_pool[i] = base + 32'(i) * 32'h0001_0203;
   endtask

   task automatic run_mixed(int count);
      for (int i = 0; i < count; i++) queue_item(mixed_item());
      drain();
   endtask

   initial begin
      logic [31:0] ip_a;
      logic [31:0] ip_b;
      logic [31:0] ip_c;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      my_mac = '0;
      my_ip = '0;
      lifetime_ms = 16'd30000;
      retry_ms = 16'd5000;
      held_count = 0;
      for (int i = 0; i < arp_pkg::CACHE_ENTRIES; i++) begin
         arp_valid[i] = 1'b0; arp_ip[i] = '0; arp_mac[i] = '0; arp_ttl[i] = '0;
      end
      for (int i = 0; i < arp_pkg::PENDING_ENTRIES; i++) begin
         wait_valid[i] = 1'b0; wait_ip[i] = '0; wait_ttl[i] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      repeat (QUIET_CYCLES) @(posedge clock);

      configure(rand_mac(), $urandom(), 16'd30000, 16'd5000);
      new_pool();
      ip_a = 32'hFFFF_FFFF;
      ip_b = 32'h0000_0000;
      ip_c = ip_pool[3];
      queue_item(send_item(ip_a, 16'h0000));
      queue_item(send_item(ip_a, 16'hFFFF));
      queue_item(send_item(ip_b, 16'h0001));
      queue_item(tick_item(16'd0));
      queue_item(tick_item(16'hFFFF));
      queue_item(arp_item(arp_pkg::OP_REPLY, ip_a, $urandom(), my_mac));
      queue_item(send_item(ip_a, 16'h1234));
      queue_item(frame_item(my_mac, arp_pkg::IPV4_ETHERTYPE, 1'b1));
      queue_item(frame_item(arp_pkg::BCAST_MAC, arp_pkg::IPV4_ETHERTYPE, 1'b1));
      queue_item(frame_item(~my_mac & 48'h7FFF_FFFF_FFFF, arp_pkg::IPV4_ETHERTYPE, 1'b1));
      queue_item(frame_item(my_mac, arp_pkg::IPV4_ETHERTYPE, 1'b0));
      queue_item(frame_item(my_mac, arp_pkg::ARP_ETHERTYPE, 1'b0));
      queue_item(frame_item(my_mac, 16'hFFFF, 1'b1));
      queue_item(arp_item(16'd3, ip_c, my_ip, my_mac));
      queue_item(arp_item(arp_pkg::OP_REQUEST, ip_c, my_ip, rand_mac()));
      queue_item(arp_item(arp_pkg::OP_REQUEST, ip_pool[4], ~my_ip, rand_mac()));
      queue_item(arp_item(arp_pkg::OP_REPLY, ip_pool[5], $urandom(), ~my_mac));
      queue_item(send_item(ip_c, 16'h00FF));
      begin
         arp_pkg::req_payload_type odd;
         odd = noise_item();
         odd.action = arp_pkg::ACT_UNDEFINED;
         queue_item(odd);
      end
      queue_item(tick_item(16'hFFFF));
      queue_item(arp_item(arp_pkg::OP_REPLY, ip_b, $urandom(), my_mac));
      drain();

      // flood: fill the pending table
      send_gap_pct = 45;
      for (int i = 0; i < 40; i++)
         queue_item(send_item($urandom(), 16'($urandom_range(65535))));
      drain();
      run_mixed(130);

      configure(rand_mac(), $urandom(), 16'd1, 16'd1);
      new_pool();
      send_gap_pct = 0;
      recv_stall_pct = 45;
      run_mixed(90);

      configure(48'hFFFF_FFFF_FFFF, 32'h0, 16'hFFFF, 16'hFFFF);
      new_pool();
      send_gap_pct = 31;
      recv_stall_pct = 31;
      run_mixed(90);

      configure(48'h0, 32'hFFFF_FFFF, 16'd700, 16'd300);
      new_pool();
      send_gap_pct = 0;
      recv_stall_pct = 0;
      for (int i = 0; i < 60; i++) queue_item(mixed_item());
      hold_arm <= ~hold_arm;
      while (queued_requests.size() > 30) @(posedge clock);
      send_hold <= 1'b1;
      while (expected_results.size() > 0 || req_if.valid) @(posedge clock);
      send_hold <= 1'b0;
      drain();

      drain();
      if (errors == 0) begin
         $display("arp_resolution_engine: match");
      end else begin
         $display("arp_resolution_engine: mismatch");
      end
      $finish;
   end
endmodule

>>> files.f
hdl/arp_pkg.sv
hdl/arp_req_if.sv
hdl/arp_rsp_if.sv
hdl/arp_out_stage.sv
hdl/arp_engine.sv
hdl/arp_resolution_engine.sv
verif/tb_arp_resolution_engine.sv
